// File: hw/rtl/oid_pkg.sv
`timescale 1ns / 1ps
// oid_pkg: shared types, phase codes and register constants for the
// two-wire optical pen sensor master. No dependencies.
package oid_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TICK_W     = 24;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned STOP_W     = 16;
  localparam int unsigned BIT_W      = 7;
  localparam int unsigned FRAME_W    = 64;

  localparam logic [HALF_W-1:0] HALF_RESET    = 16'd10;
  localparam logic [STOP_W-1:0] STOP_RESET    = 16'd78;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd300000;

  localparam logic [BIT_W-1:0] FRAME_BITS = 7'd64;
  localparam logic [BIT_W-1:0] ACK_BITS   = 7'd16;
  localparam logic [BIT_W-1:0] CMD_BITS   = 7'd8;

  typedef enum logic [1:0] {
    REG_HALF_PERIOD = 2'd0,
    REG_STOP        = 2'd1,
    REG_ACK_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACK_OK      = 2'd0,
    ACK_TIMEOUT = 2'd1,
    ACK_WRONG   = 2'd2
  } ack_status_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RX_HI    = 4'd1,
    PH_RX_LO    = 4'd2,
    PH_RX_STOP  = 4'd3,
    PH_TX_HI    = 4'd4,
    PH_TX_LO    = 4'd5,
    PH_TX_STOP  = 4'd6,
    PH_ACK_WAIT = 4'd7
  } phase_t;

  typedef struct packed {
    logic       sda_in;
    logic       cmd_valid;
    logic [7:0] cmd_byte;
  } in_t;

  typedef struct packed {
    logic               scl_level;
    logic               sda_pull_low;
    logic               busy_res;
    logic               frame_done;
    logic [FRAME_W-1:0] frame_word;
    logic               is_command;
    logic [13:0]        position_x;
    logic [13:0]        position_y;
    logic [25:0]        code_value;
    logic               ack_done;
    logic [1:0]         ack_status;
  } out_t;

  typedef struct packed {
    logic [HALF_W-1:0] half_period_ticks;
    logic [STOP_W-1:0] stop_ticks;
    logic [TICK_W-1:0] ack_timeout_ticks;
  } cfg_t;

endpackage

// File: hw/rtl/oid_two_wire_master.sv
`timescale 1ns / 1ps
// oid_two_wire_master: top level of the two-wire optical pen sensor master.
// Depends on oid_pkg, oid_cfg_regs and oid_core.
//
//  port group  direction  handshake            payload
//  in_         to block   in_valid / in_stall  in_data   (oid_pkg::in_t)
//  out_        from block out_valid / out_stall out_data (oid_pkg::out_t)
//  cfg (APB)   to block   psel/penable/pready  paddr, pwdata, prdata
//
// One input transfer is one link tick; its result is in the output register
// the next cycle, and a new tick is taken every cycle while out_stall is low.
// The result is held in the single output register.
// in_stall follows the output register: high while a result is held and
// out_stall is high. Reset (rst_n low, synchronous) returns the link to idle
// and loads register defaults.
module oid_two_wire_master (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  oid_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output oid_pkg::out_t                    out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [oid_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [oid_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [oid_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import oid_pkg::*;

  cfg_t  cfg;
  out_t  res;
  out_t  out_data_r;
  logic  out_valid_r;
  logic  accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  oid_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  oid_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (accept),
    .cfg     (cfg),
    .in_item (in_data),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/oid_cfg_regs.sv
`timescale 1ns / 1ps
// oid_cfg_regs: APB-style register file for bit timing and ack timeout.
// Depends on oid_pkg.
module oid_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [oid_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [oid_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [oid_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output oid_pkg::cfg_t                    cfg
);
  import oid_pkg::*;

  logic [HALF_W-1:0] half_r;
  logic [STOP_W-1:0] stop_r;
  logic [TICK_W-1:0] timeout_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= HALF_RESET;
      stop_r    <= STOP_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_HALF_PERIOD: half_r    <= pwdata[HALF_W-1:0];
        REG_STOP:        stop_r    <= pwdata[STOP_W-1:0];
        REG_ACK_TIMEOUT: timeout_r <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_HALF_PERIOD: prdata = {{(CFG_DATA_W-HALF_W){1'b0}}, half_r};
      REG_STOP:        prdata = {{(CFG_DATA_W-STOP_W){1'b0}}, stop_r};
      REG_ACK_TIMEOUT: prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, timeout_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.half_period_ticks = half_r;
  assign cfg.stop_ticks        = stop_r;
  assign cfg.ack_timeout_ticks = timeout_r;

endmodule

// File: hw/rtl/oid_core.sv
`timescale 1ns / 1ps
// oid_core: link state registers and the per-tick next-state and result logic.
// Depends on oid_pkg.
module oid_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tick_en,
  input  oid_pkg::cfg_t cfg,
  input  oid_pkg::in_t  in_item,
  output oid_pkg::out_t res
);
  import oid_pkg::*;

  typedef struct packed {
    logic              done;
    logic [TICK_W-1:0] count;
  } run_t;

  function automatic run_t run_out(input logic [TICK_W-1:0] tc,
                                   input logic [TICK_W-1:0] dur);
    run_t r;
    logic [TICK_W-1:0] t;
    t       = tc + 1'b1;
    r.done  = (t >= dur);
    r.count = r.done ? '0 : t;
    return r;
  endfunction

  function automatic logic tx_bit(input logic [BIT_W-1:0] b, input logic [7:0] cmd);
    logic [3:0] sub;
    sub = 4'd8 - b[3:0];
    if (b == '0 || b > CMD_BITS) return 1'b1;
    return cmd[sub[2:0]];
  endfunction

  phase_t             phase_r, phase_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [FRAME_W-1:0] shift_r, shift_nxt;
  logic [7:0]         pcmd_r, pcmd_nxt;
  logic               pflag_r, pflag_nxt;
  logic               rx_ack_r, rx_ack_nxt;

  run_t               ro_half, ro_stop, ro_to;
  logic               fdone, adone;
  ack_status_t        astat;
  logic [7:0]         ack_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      pcmd_r   <= '0;
      pflag_r  <= 1'b0;
      rx_ack_r <= 1'b0;
    end else if (tick_en) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      pcmd_r   <= pcmd_nxt;
      pflag_r  <= pflag_nxt;
      rx_ack_r <= rx_ack_nxt;
    end
  end

  assign ro_half = run_out(tick_r, {{(TICK_W-HALF_W){1'b0}}, cfg.half_period_ticks});
  assign ro_stop = run_out(tick_r, {{(TICK_W-STOP_W){1'b0}}, cfg.stop_ticks});
  assign ro_to   = run_out(tick_r, cfg.ack_timeout_ticks);
  assign ack_low = shift_r[7:0] - 8'd1;

  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    pcmd_nxt   = pcmd_r;
    pflag_nxt  = pflag_r;
    rx_ack_nxt = rx_ack_r;
    fdone      = 1'b0;
    adone      = 1'b0;
    astat      = ACK_OK;

    unique case (phase_r)
      PH_IDLE: begin
        if (!in_item.sda_in) begin
          phase_nxt  = PH_RX_HI;
          tick_nxt   = '0;
          bit_nxt    = '0;
          shift_nxt  = '0;
          rx_ack_nxt = 1'b0;
          if (in_item.cmd_valid) begin
            pcmd_nxt  = in_item.cmd_byte;
            pflag_nxt = 1'b1;
          end
        end else if (in_item.cmd_valid) begin
          pcmd_nxt  = in_item.cmd_byte;
          phase_nxt = PH_TX_HI;
          tick_nxt  = '0;
          bit_nxt   = '0;
          pflag_nxt = 1'b0;
        end
      end
      PH_RX_HI: begin
        tick_nxt = ro_half.count;
        if (ro_half.done) phase_nxt = PH_RX_LO;
      end
      PH_RX_LO: begin
        // sample on first tick of each low half, start bit excluded
        if (tick_r == '0 && bit_r != '0) shift_nxt = {shift_r[FRAME_W-2:0], in_item.sda_in};
        tick_nxt = ro_half.count;
        if (ro_half.done) begin
          if (bit_r >= (rx_ack_r ? ACK_BITS : FRAME_BITS)) begin
            phase_nxt = PH_RX_STOP;
          end else begin
            bit_nxt   = bit_r + 1'b1;
            phase_nxt = PH_RX_HI;
          end
        end
      end
      PH_RX_STOP: begin
        tick_nxt = ro_stop.count;
        if (ro_stop.done) begin
          phase_nxt = PH_IDLE;
          if (rx_ack_r) begin
            adone = 1'b1;
            astat = (ack_low == pcmd_r) ? ACK_OK : ACK_WRONG;
          end else begin
            fdone = 1'b1;
            if (pflag_r) begin
              phase_nxt = PH_TX_HI;
              tick_nxt  = '0;
              bit_nxt   = '0;
              pflag_nxt = 1'b0;
            end
          end
        end
      end
      PH_TX_HI: begin
        tick_nxt = ro_half.count;
        if (ro_half.done) phase_nxt = PH_TX_LO;
      end
      PH_TX_LO: begin
        tick_nxt = ro_half.count;
        if (ro_half.done) begin
          if (bit_r >= CMD_BITS) begin
            phase_nxt = PH_TX_STOP;
          end else begin
            bit_nxt   = bit_r + 1'b1;
            phase_nxt = PH_TX_HI;
          end
        end
      end
      PH_TX_STOP: begin
        tick_nxt = ro_stop.count;
        if (ro_stop.done) phase_nxt = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        if (!in_item.sda_in) begin
          phase_nxt  = PH_RX_HI;
          tick_nxt   = '0;
          bit_nxt    = '0;
          shift_nxt  = '0;
          rx_ack_nxt = 1'b1;
        end else begin
          tick_nxt = ro_to.count;
          if (ro_to.done) begin
            phase_nxt = PH_IDLE;
            adone     = 1'b1;
            astat     = ACK_TIMEOUT;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase
  end

  // line levels follow the state after this tick
  always_comb begin
    res = '0;
    unique case (phase_nxt)
      PH_RX_HI: begin
        res.scl_level    = 1'b1;
        res.sda_pull_low = (bit_nxt == '0);
      end
      PH_RX_LO: res.sda_pull_low = (bit_nxt == '0);
      PH_TX_HI: begin
        res.scl_level    = 1'b1;
        res.sda_pull_low = ~tx_bit(bit_nxt, pcmd_nxt);
      end
      PH_TX_LO: res.sda_pull_low = (bit_nxt >= 7'd1 && bit_nxt <= 7'd7) ?
                                   ~tx_bit(bit_nxt, pcmd_nxt) : 1'b0;
      default: ;
    endcase
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.frame_done = fdone;
    res.ack_done   = adone;
    res.ack_status = adone ? astat : ACK_OK;
    if (fdone) begin
      res.frame_word = shift_r;
      res.is_command = shift_r[63];
      if (shift_r[63]) begin
        res.code_value = {10'd0, shift_r[15:0]};
      end else if (shift_r[62]) begin
        if (shift_r[61]) begin
          res.position_x = shift_r[13:0];
          res.position_y = shift_r[27:14];
        end else begin
          res.code_value = shift_r[25:0];
        end
      end else begin
        res.code_value = {10'd0, shift_r[15:0]};
      end
    end
  end

endmodule
